// ----- rtl/lgge_pkg.sv -----
package lgge_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 256;
  localparam int ROW_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int COORD_W   = 8;
  localparam int COORD_N   = 1 << COORD_W;
  localparam int NB_W      = 4;

  // Life rule thresholds
  localparam int LIVE_KEEP  = 2;
  localparam int LIVE_BIRTH = 3;

  typedef logic [GRID_SIZE-1:0] row_t;
  typedef logic [ROW_W-1:0]     idx_t;
  typedef logic [NB_W-1:0]      nb_cnt_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Coordinate wrap table, built at elaboration
  typedef idx_t wrap_tab_t [COORD_N];

  function automatic wrap_tab_t build_wrap();
    wrap_tab_t t;
    for (int i = 0; i < COORD_N; i++) begin
      t[i] = idx_t'(i % GRID_SIZE);
    end
    return t;
  endfunction

  localparam wrap_tab_t WRAP_TAB = build_wrap();

endpackage

// ----- rtl/lgge_if.sv -----
interface lgge_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [lgge_pkg::COORD_W-1:0]   cell_row;
  logic [lgge_pkg::COORD_W-1:0]   cell_col;
  logic                           cell_in;

  modport source (output valid, action, cell_row, cell_col, cell_in, input ready);
  modport sink   (input valid, action, cell_row, cell_col, cell_in, output ready);
endinterface

interface lgge_out_if;
  logic       valid;
  logic       ready;
  logic       cell_out;
  logic [1:0] done_action;

  modport source (output valid, cell_out, done_action, input ready);
  modport sink   (input valid, cell_out, done_action, output ready);
endinterface

// ----- rtl/lgge_ram.sv -----
module lgge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lgge_row_update.sv -----
module lgge_row_update (
  input  lgge_pkg::row_t prev_row,
  input  lgge_pkg::row_t cur_row,
  input  lgge_pkg::row_t next_row,
  output lgge_pkg::row_t new_row
);

  // One lane per column, neighbors wrap around the row ends
  for (genvar c = 0; c < lgge_pkg::GRID_SIZE; c++) begin : g_lane
    localparam int L = (c + lgge_pkg::GRID_SIZE - 1) % lgge_pkg::GRID_SIZE;
    localparam int R = (c + 1) % lgge_pkg::GRID_SIZE;
    lgge_pkg::nb_cnt_t nb;

    always_comb begin
      nb = lgge_pkg::nb_cnt_t'(prev_row[L]) + lgge_pkg::nb_cnt_t'(prev_row[c])
         + lgge_pkg::nb_cnt_t'(prev_row[R]) + lgge_pkg::nb_cnt_t'(cur_row[L])
         + lgge_pkg::nb_cnt_t'(cur_row[R])  + lgge_pkg::nb_cnt_t'(next_row[L])
         + lgge_pkg::nb_cnt_t'(next_row[c]) + lgge_pkg::nb_cnt_t'(next_row[R]);
      new_row[c] = (nb == lgge_pkg::nb_cnt_t'(lgge_pkg::LIVE_BIRTH))
                 | (cur_row[c] & (nb == lgge_pkg::nb_cnt_t'(lgge_pkg::LIVE_KEEP)));
    end
  end

endmodule

// ----- rtl/life_grid_generation_engine_top.sv -----
// Read, write and unknown actions: the accepted transaction passes through S_MEM and S_RESP.
// Generation step: S_ST_A and S_ST_B fetch the last row and row 0, then S_ST_RUN; the single grid
// memory read port delivers one row per cycle and every row is rewritten once.
// One transaction is in work at a time; a finished result waits in the output register.
// Reset: synchronous, active low; a clearing pass then writes GRID_SIZE rows
// of dead cells while in_ch.ready stays low.
module life_grid_generation_engine_top (
  input  logic              clk,
  input  logic              rst_n,
  lgge_in_if.sink           in_ch,
  lgge_out_if.source        out_ch
);

  localparam lgge_pkg::idx_t LAST_ROW = lgge_pkg::idx_t'(lgge_pkg::GRID_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MEM,
    S_ST_A,
    S_ST_B,
    S_ST_RUN,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  lgge_pkg::idx_t     cnt_r, cnt_nxt;
  lgge_pkg::action_t  act_r, act_nxt;
  lgge_pkg::idx_t     row_r, row_nxt;
  lgge_pkg::idx_t     col_r, col_nxt;
  logic               val_r, val_nxt;
  logic               res_cell_r, res_cell_nxt;
  lgge_pkg::row_t     prev_r, prev_nxt;
  lgge_pkg::row_t     cur_r, cur_nxt;
  lgge_pkg::row_t     first_r, first_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_cell_r, out_cell_nxt;
  logic [1:0]         out_action_r, out_action_nxt;

  logic               wr_en, rd_en;
  lgge_pkg::idx_t     wr_addr, rd_addr;
  lgge_pkg::row_t     wr_data, rd_data;
  lgge_pkg::row_t     next_row, upd_row, mod_row;
  logic               in_fire;

  lgge_ram #(
    .WIDTH (lgge_pkg::GRID_SIZE),
    .DEPTH (lgge_pkg::GRID_SIZE)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgge_row_update u_rule (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (next_row),
    .new_row  (upd_row)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid & in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cell_out    = out_cell_r;
  assign out_ch.done_action = out_action_r;

  // Last row of a step takes the saved old row 0 as its lower neighbor
  assign next_row = (cnt_r == LAST_ROW) ? first_r : rd_data;

  // Patch one cell into the fetched row
  always_comb begin
    mod_row        = rd_data;
    mod_row[col_r] = val_r;
  end

  // Sequence memory accesses and result hand-off
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    act_nxt        = act_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    val_nxt        = val_r;
    res_cell_nxt   = res_cell_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    out_cell_nxt   = out_cell_r;
    out_action_nxt = out_action_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_r;
    wr_data        = upd_row;
    rd_en          = 1'b0;
    rd_addr        = cnt_r;

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        cnt_nxt = cnt_r + lgge_pkg::idx_t'(1);
        if (cnt_r == LAST_ROW) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          act_nxt      = lgge_pkg::action_t'(in_ch.action);
          row_nxt      = lgge_pkg::WRAP_TAB[in_ch.cell_row];
          col_nxt      = lgge_pkg::WRAP_TAB[in_ch.cell_col];
          val_nxt      = in_ch.cell_in;
          res_cell_nxt = 1'b0;
          rd_en        = 1'b1;
          if (lgge_pkg::action_t'(in_ch.action) == lgge_pkg::ACT_STEP) begin
            rd_addr   = LAST_ROW;
            state_nxt = S_ST_A;
          end else begin
            rd_addr   = lgge_pkg::WRAP_TAB[in_ch.cell_row];
            state_nxt = S_MEM;
          end
        end
      end
      S_MEM: begin
        if (act_r == lgge_pkg::ACT_WRITE) begin
          wr_en   = 1'b1;
          wr_addr = row_r;
          wr_data = mod_row;
        end
        if (act_r == lgge_pkg::ACT_READ) begin
          res_cell_nxt = rd_data[col_r];
        end
        state_nxt = S_RESP;
      end
      S_ST_A: begin
        prev_nxt  = rd_data;
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = S_ST_B;
      end
      S_ST_B: begin
        cur_nxt   = rd_data;
        first_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = lgge_pkg::idx_t'(1);
        cnt_nxt   = '0;
        state_nxt = S_ST_RUN;
      end
      S_ST_RUN: begin
        wr_en    = 1'b1;
        wr_addr  = cnt_r;
        wr_data  = upd_row;
        prev_nxt = cur_r;
        cur_nxt  = next_row;
        if (cnt_r < LAST_ROW - lgge_pkg::idx_t'(1)) begin
          rd_en   = 1'b1;
          rd_addr = cnt_r + lgge_pkg::idx_t'(2);
        end
        cnt_nxt = cnt_r + lgge_pkg::idx_t'(1);
        if (cnt_r == LAST_ROW) begin
          cnt_nxt   = '0;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_cell_nxt   = res_cell_r;
          out_action_nxt = act_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    val_r        <= val_nxt;
    res_cell_r   <= res_cell_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    first_r      <= first_nxt;
    out_cell_r   <= out_cell_nxt;
    out_action_r <= out_action_nxt;
  end

`ifndef SYNTHESIS
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("grid memory written while idle");

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("row read and written in the same cycle");

  a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_action_r != lgge_pkg::ACT_READ)) |-> !out_cell_r)
    else $error("cell_out set on a non-read result");

  a_resp_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && !out_ch.ready) |=> (state_r == S_RESP))
    else $error("result dropped while output register busy");
`endif

endmodule

// ----- bench/life_grid_checker.sv -----
`timescale 1ns / 1ps

module life_grid_checker
  import lgge_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lgge_in_if   in_mon,
  lgge_out_if  out_mon,
  output int   fail_count,
  output int   pending_results,
  output int   live_reads
);

  typedef struct packed {
    logic    cell_out;
    action_t done_action;
  } life_result_t;

  typedef bit [GRID_SIZE-1:0] life_row_t;

  // Mirror of the grid, one packed vector per row, bit index = column
  life_row_t    life_map [GRID_SIZE];
  life_result_t expected_q [$];
  int           result_idx;

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= 20) begin
      $display("[%0t] result %0d mismatch: %s", $time, result_idx, what);
    end
  endtask

  // Advance every cell at once: per row, sum the eight neighbor vectors
  // into a 4-bit counter held as four bit planes, then apply the rule.
  function automatic void advance_life();
    life_row_t prev [GRID_SIZE];
    life_row_t nb [9];
    life_row_t band, c0, c1, c2, c3, carry, t1;
    prev = life_map;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int k = 0; k < 3; k++) begin
        band = prev[(r + GRID_SIZE - 1 + k) % GRID_SIZE];
        nb[3*k]   = {band[GRID_SIZE-2:0], band[GRID_SIZE-1]};
        nb[3*k+1] = {band[0], band[GRID_SIZE-1:1]};
        nb[3*k+2] = (k == 1) ? '0 : band;
      end
      c0 = '0;
      c1 = '0;
      c2 = '0;
      c3 = '0;
      foreach (nb[k]) begin
        carry = c0 & nb[k];
        c0    = c0 ^ nb[k];
        t1    = c1 & carry;
        c1    = c1 ^ carry;
        c3    = c3 | (c2 & t1);
        c2    = c2 ^ t1;
      end
      // live with 2 or 3 stays, dead with exactly 3 is born
      life_map[r] = ~c3 & ~c2 & c1 & (c0 | prev[r]);
    end
  endfunction

  function automatic life_result_t apply_action(action_t act, logic [COORD_W-1:0] row,
                                                logic [COORD_W-1:0] col, logic value);
    life_result_t res;
    int r;
    int c;
    r = int'(row) % GRID_SIZE;
    c = int'(col) % GRID_SIZE;
    res.cell_out    = 1'b0;
    res.done_action = act;
    case (act)
      ACT_WRITE: life_map[r][c] = value;
      ACT_STEP:  advance_life();
      ACT_READ:  res.cell_out = life_map[r][c];
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_result(logic got_cell, logic [1:0] got_act);
    life_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction, cell_out %0b done_action %0d",
                                got_cell, got_act));
      return;
    end
    want = expected_q.pop_front();
    if (got_act !== want.done_action) begin
      report_mismatch($sformatf("done_action got %0d want %0d", got_act, want.done_action));
    end
    if (got_cell !== want.cell_out) begin
      report_mismatch($sformatf("cell_out got %0b want %0b (action %s)",
                                got_cell, want.cell_out, want.done_action.name()));
    end
  endtask

  // Compare results first, then predict the newly accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      foreach (life_map[r]) life_map[r] = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result(out_mon.cell_out, out_mon.done_action);
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(apply_action(action_t'(in_mon.action), in_mon.cell_row,
                                          in_mon.cell_col, in_mon.cell_in));
        if (expected_q[$].done_action == ACT_READ && expected_q[$].cell_out) begin
          live_reads++;
        end
      end
    end
    pending_results <= expected_q.size();
  end

endmodule

// ----- bench/life_grid_generation_engine_top_test.sv -----
`timescale 1ns / 1ps

module life_grid_generation_engine_top_test;
  import lgge_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 700;
  localparam int RANDOM_ITEMS = 72;

  logic clk;
  logic rst_n;

  lgge_in_if  in_ch ();
  lgge_out_if out_ch ();

  int fail_count;
  int pending_results;
  int live_reads;
  int cycle_count;
  int issued;
  int burst_left;
  bit gaps_off;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int sent_by_action [4];

  life_grid_generation_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  life_grid_checker life_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .live_reads      (live_reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_results);
    $display("simulation failed");
    $finish;
  end

  // Result side: phases of full speed, light and heavy stalls, plus one long hold-off
  initial begin : result_sink
    int phase_left;
    int stall_mode;
    phase_left = 0;
    stall_mode = 0;
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one transaction and hold it until accepted; drop valid for a gap
  // when the current burst runs out.
  task automatic issue(action_t act, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                       logic value);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.cell_row <= row;
    in_ch.cell_col <= col;
    in_ch.cell_in  <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    issued++;
    sent_by_action[act]++;
    if (!gaps_off) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20)
                                                 : $urandom_range(0, 5);
      end
    end
  endtask

  // Hold the input idle until every outstanding result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Favor corners so patterns straddle the wrap-around edges
  function automatic logic [COORD_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return COORD_W'($urandom_range(COORD_N - 3, COORD_N - 1));
      1:       return COORD_W'($urandom_range(0, 2));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Seed a small dense patch, evolve it a few generations, then probe around it
  task automatic life_episode();
    logic [COORD_W-1:0] r0;
    logic [COORD_W-1:0] c0;
    r0 = pick_origin();
    c0 = pick_origin();
    repeat ($urandom_range(3, 8)) begin
      issue(ACT_WRITE, r0 + COORD_W'($urandom_range(0, 3)), c0 + COORD_W'($urandom_range(0, 3)),
            $urandom_range(0, 3) != 0);
    end
    repeat ($urandom_range(1, 3)) begin
      issue(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
    end
    repeat ($urandom_range(3, 6)) begin
      issue(ACT_READ, r0 - COORD_W'(1) + COORD_W'($urandom_range(0, 5)),
            c0 - COORD_W'(1) + COORD_W'($urandom_range(0, 5)), 1'($urandom));
    end
  endtask

  task automatic noise_item();
    issue(action_t'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
          1'($urandom));
  endtask

  initial begin : stimulus
    int directed_end;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_NONE;
    in_ch.cell_row <= '0;
    in_ch.cell_col <= '0;
    in_ch.cell_in  <= 1'b0;
    rst_n          <= 1'b0;
    issued     = 0;
    burst_left = 4;
    gaps_off   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Cleared grid, corner cells, write of both values, unknown action, step of an empty grid
    issue(ACT_READ, 8'd0, 8'd0, 1'b0);
    issue(ACT_READ, 8'd255, 8'd255, 1'b1);
    issue(ACT_WRITE, 8'd0, 8'd0, 1'b1);
    issue(ACT_READ, 8'd0, 8'd0, 1'b0);
    issue(ACT_WRITE, 8'd0, 8'd0, 1'b0);
    issue(ACT_READ, 8'd0, 8'd0, 1'b1);
    issue(ACT_NONE, 8'd255, 8'd255, 1'b1);
    issue(ACT_NONE, 8'd0, 8'd0, 1'b0);
    issue(ACT_STEP, 8'd0, 8'd0, 1'b0);

    // Blinker across the row wrap; it flips across the column wrap
    issue(ACT_WRITE, 8'd255, 8'd0, 1'b1);
    issue(ACT_WRITE, 8'd0, 8'd0, 1'b1);
    issue(ACT_WRITE, 8'd1, 8'd0, 1'b1);
    issue(ACT_STEP, 8'd255, 8'd255, 1'b1);
    issue(ACT_READ, 8'd0, 8'd255, 1'b0);
    issue(ACT_READ, 8'd0, 8'd0, 1'b0);
    issue(ACT_READ, 8'd0, 8'd1, 1'b0);
    issue(ACT_READ, 8'd255, 8'd0, 1'b0);
    issue(ACT_STEP, 8'd0, 8'd0, 1'b0);
    issue(ACT_READ, 8'd255, 8'd0, 1'b0);

    // Overcrowded cell dies, neighbor with three is born
    issue(ACT_WRITE, 8'd100, 8'd100, 1'b1);
    issue(ACT_WRITE, 8'd100, 8'd101, 1'b1);
    issue(ACT_WRITE, 8'd101, 8'd100, 1'b1);
    issue(ACT_WRITE, 8'd101, 8'd101, 1'b1);
    issue(ACT_WRITE, 8'd99, 8'd100, 1'b1);
    issue(ACT_STEP, 8'd0, 8'd0, 1'b0);
    issue(ACT_READ, 8'd100, 8'd100, 1'b0);
    issue(ACT_READ, 8'd99, 8'd101, 1'b0);
    drain_results();
    directed_end = issued;

    // Random part: mostly seeded episodes, some stray transactions
    while (issued < directed_end + RANDOM_ITEMS) begin
      if (!hold_req && issued >= directed_end + 20) begin
        // back up the block behind a long result stall
        hold_req <= 1'b1;
        gaps_off = 1'b1;
        repeat (8) noise_item();
        gaps_off = 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        life_episode();
      end else begin
        noise_item();
      end
      if ($urandom_range(0, 5) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d writes, %0d generation steps, %0d reads (%0d live), %0d no-op actions",
             sent_by_action[ACT_WRITE], sent_by_action[ACT_STEP], sent_by_action[ACT_READ],
             live_reads, sent_by_action[ACT_NONE]);
    $display("long result hold-off of %0d cycles %s, %0d mismatches in %0d cycles",
             HOLD_CYCLES, hold_done ? "exercised" : "not reached", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lgge_pkg.sv
rtl/lgge_if.sv
rtl/lgge_ram.sv
rtl/lgge_row_update.sv
rtl/life_grid_generation_engine_top.sv
bench/life_grid_checker.sv
bench/life_grid_generation_engine_top_test.sv
